/* rtl/sm83cf_pkg.sv */
// sm83cf_pkg: opcode and condition codes, flag positions, and the request and
// result records shared by the control-flow unit's modules. no dependencies.
package sm83cf_pkg;

  typedef enum logic [4:0] {
    OP_NOP     = 5'd0,
    OP_CCF     = 5'd1,
    OP_SCF     = 5'd2,
    OP_HALT    = 5'd3,
    OP_STOP    = 5'd4,
    OP_DI      = 5'd5,
    OP_EI      = 5'd6,
    OP_JP      = 5'd7,
    OP_JP_HL   = 5'd8,
    OP_JP_CC   = 5'd9,
    OP_JR      = 5'd10,
    OP_JR_CC   = 5'd11,
    OP_CALL    = 5'd12,
    OP_CALL_CC = 5'd13,
    OP_RET     = 5'd14,
    OP_RETI    = 5'd15,
    OP_RET_CC  = 5'd16,
    OP_RST     = 5'd17,
    OP_UNUSED  = 5'd18
  } op_e;

  typedef enum logic [1:0] {
    CC_NZ = 2'd0,
    CC_Z  = 2'd1,
    CC_NC = 2'd2,
    CC_C  = 2'd3
  } cond_e;

  // flag bit positions in the 4-bit flag word
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [4:0]  IntMask = 5'h1F;
  localparam logic [15:0] RstMask = 16'h0038;

  localparam logic [1:0] ExtraNone = 2'd0;
  localparam logic [1:0] ExtraOne  = 2'd1;
  localparam logic [1:0] ExtraTwo  = 2'd2;

  typedef struct packed {
    logic [4:0]  req_type;
    logic [1:0]  cond;
    logic [15:0] pc_in;
    logic [15:0] sp_in;
    logic [15:0] hl_value;
    logic [15:0] immediate;
    logic [3:0]  flags_in;
    logic [15:0] stack_word;
    logic [4:0]  int_pending;
    logic        ime_in;
    logic        ime_delay_in;
  } req_t;

  typedef struct packed {
    logic [15:0] pc_out;
    logic [15:0] sp_out;
    logic [3:0]  flags_out;
    logic        ime_out;
    logic        ime_delay_out;
    logic        halt_enter;
    logic        halt_bug_set;
    logic        push_en;
    logic [15:0] push_data;
    logic        pop_en;
    logic [1:0]  extra_mcycles;
  } res_t;

endpackage

/* rtl/sm83cf_exec.sv */
// sm83cf_exec: combinational execute stage, decodes one registered request and
// computes the new machine state. depends on sm83cf_pkg.
module sm83cf_exec (
  input  sm83cf_pkg::req_t req_i,
  output sm83cf_pkg::res_t res_o
);
  import sm83cf_pkg::*;

  logic        taken;
  logic [15:0] jr_off;
  logic [15:0] jr_target;
  logic [15:0] sp_dec;
  logic [15:0] sp_inc;
  op_e         op;

  assign op        = op_e'(req_i.req_type);
  assign jr_off    = {{8{req_i.immediate[7]}}, req_i.immediate[7:0]};
  assign jr_target = req_i.pc_in + jr_off;
  assign sp_dec    = req_i.sp_in - 16'd2;
  assign sp_inc    = req_i.sp_in + 16'd2;

  always_comb begin
    unique case (cond_e'(req_i.cond))
      CC_NZ:   taken = ~req_i.flags_in[FlagZ];
      CC_Z:    taken =  req_i.flags_in[FlagZ];
      CC_NC:   taken = ~req_i.flags_in[FlagC];
      CC_C:    taken =  req_i.flags_in[FlagC];
      default: taken = 1'b0;
    endcase
  end

  always_comb begin
    res_o               = '0;
    res_o.pc_out        = req_i.pc_in;
    res_o.sp_out        = req_i.sp_in;
    res_o.flags_out     = req_i.flags_in;
    res_o.ime_out       = req_i.ime_in;
    res_o.ime_delay_out = req_i.ime_delay_in;
    res_o.push_data     = req_i.pc_in;
    res_o.extra_mcycles = ExtraNone;

    unique case (op)
      OP_CCF: begin
        res_o.flags_out        = '0;
        res_o.flags_out[FlagZ] = req_i.flags_in[FlagZ];
        res_o.flags_out[FlagC] = ~req_i.flags_in[FlagC];
      end
      OP_SCF: begin
        res_o.flags_out        = '0;
        res_o.flags_out[FlagZ] = req_i.flags_in[FlagZ];
        res_o.flags_out[FlagC] = 1'b1;
      end
      OP_HALT: begin
        // pending enabled interrupt with master enable off: halt bug
        if (((req_i.int_pending & IntMask) != '0) && !req_i.ime_in) begin
          res_o.halt_bug_set = 1'b1;
        end else begin
          res_o.halt_enter = 1'b1;
        end
      end
      OP_DI: begin
        res_o.ime_out       = 1'b0;
        res_o.ime_delay_out = 1'b0;
      end
      OP_EI: begin
        res_o.ime_delay_out = 1'b1;
      end
      OP_JP: begin
        res_o.pc_out        = req_i.immediate;
        res_o.extra_mcycles = ExtraOne;
      end
      OP_JP_HL: begin
        res_o.pc_out = req_i.hl_value;
      end
      OP_JP_CC: begin
        if (taken) begin
          res_o.pc_out        = req_i.immediate;
          res_o.extra_mcycles = ExtraOne;
        end
      end
      OP_JR: begin
        res_o.pc_out        = jr_target;
        res_o.extra_mcycles = ExtraOne;
      end
      OP_JR_CC: begin
        if (taken) begin
          res_o.pc_out        = jr_target;
          res_o.extra_mcycles = ExtraOne;
        end
      end
      OP_CALL: begin
        res_o.sp_out        = sp_dec;
        res_o.push_en       = 1'b1;
        res_o.pc_out        = req_i.immediate;
        res_o.extra_mcycles = ExtraOne;
      end
      OP_CALL_CC: begin
        if (taken) begin
          res_o.sp_out        = sp_dec;
          res_o.push_en       = 1'b1;
          res_o.pc_out        = req_i.immediate;
          res_o.extra_mcycles = ExtraOne;
        end
      end
      OP_RET: begin
        res_o.pc_out        = req_i.stack_word;
        res_o.sp_out        = sp_inc;
        res_o.pop_en        = 1'b1;
        res_o.extra_mcycles = ExtraOne;
      end
      OP_RETI: begin
        res_o.ime_delay_out = 1'b1;
        res_o.pc_out        = req_i.stack_word;
        res_o.sp_out        = sp_inc;
        res_o.pop_en        = 1'b1;
        res_o.extra_mcycles = ExtraOne;
      end
      OP_RET_CC: begin
        // the condition test still charges ExtraOne even when not taken
        res_o.extra_mcycles = ExtraOne;
        if (taken) begin
          res_o.pc_out        = req_i.stack_word;
          res_o.sp_out        = sp_inc;
          res_o.pop_en        = 1'b1;
          res_o.extra_mcycles = ExtraTwo;
        end
      end
      OP_RST: begin
        res_o.sp_out        = sp_dec;
        res_o.push_en       = 1'b1;
        res_o.pc_out        = req_i.immediate & RstMask;
        res_o.extra_mcycles = ExtraOne;
      end
      default: begin
        // nop, stop, unused and out-of-range codes leave everything alone
      end
    endcase
  end

endmodule

/* rtl/sm83_control_flow_unit_core.sv */
// sm83_control_flow_unit_core: top level of the control-flow unit, request
// register, execute stage and result register. depends on sm83cf_pkg, sm83cf_exec.
//
//   channel   | handshake            | payload
//   ----------+----------------------+------------------------------------------
//   request   | start_i / busy_o     | req_type_i .. ime_delay_in_i
//   result    | done_o (one cycle)   | pc_out_o .. extra_mcycles_o
//
// a request is taken on every clock edge with start_i high; busy_o stays low
// a result reaches the ports through the request register and the result
// register, one per request, in order
// the path is request register, one decode/add stage, result register
// reset clears only the two valid flags, payload registers are not reset
// the receiver cannot stall, so no backpressure path exists
module sm83_control_flow_unit_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  // request channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [4:0]  req_type_i,
  input  logic [1:0]  cond_i,
  input  logic [15:0] pc_in_i,
  input  logic [15:0] sp_in_i,
  input  logic [15:0] hl_value_i,
  input  logic [15:0] immediate_i,
  input  logic [3:0]  flags_in_i,
  input  logic [15:0] stack_word_i,
  input  logic [4:0]  int_pending_i,
  input  logic        ime_in_i,
  input  logic        ime_delay_in_i,

  // result channel
  output logic        done_o,
  output logic [15:0] pc_out_o,
  output logic [15:0] sp_out_o,
  output logic [3:0]  flags_out_o,
  output logic        ime_out_o,
  output logic        ime_delay_out_o,
  output logic        halt_enter_o,
  output logic        halt_bug_set_o,
  output logic        push_en_o,
  output logic [15:0] push_data_o,
  output logic        pop_en_o,
  output logic [1:0]  extra_mcycles_o
);
  import sm83cf_pkg::*;

  // request register stage
  req_t req_d, req_q;
  logic req_valid_q;

  // result register stage
  res_t res_d, res_q;
  logic res_valid_q;

  // two-register pipeline, one request per cycle, never stalls
  assign busy_o = 1'b0;

  assign req_d = '{
    req_type:     req_type_i,
    cond:         cond_i,
    pc_in:        pc_in_i,
    sp_in:        sp_in_i,
    hl_value:     hl_value_i,
    immediate:    immediate_i,
    flags_in:     flags_in_i,
    stack_word:   stack_word_i,
    int_pending:  int_pending_i,
    ime_in:       ime_in_i,
    ime_delay_in: ime_delay_in_i
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i && !busy_o;
      res_valid_q <= req_valid_q;
    end
  end

  // payload only loads on a live request, holds otherwise
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_d;
    end
    if (req_valid_q) begin
      res_q <= res_d;
    end
  end

  sm83cf_exec u_exec (
    .req_i (req_q),
    .res_o (res_d)
  );

  assign done_o          = res_valid_q;
  assign pc_out_o        = res_q.pc_out;
  assign sp_out_o        = res_q.sp_out;
  assign flags_out_o     = res_q.flags_out;
  assign ime_out_o       = res_q.ime_out;
  assign ime_delay_out_o = res_q.ime_delay_out;
  assign halt_enter_o    = res_q.halt_enter;
  assign halt_bug_set_o  = res_q.halt_bug_set;
  assign push_en_o       = res_q.push_en;
  assign push_data_o     = res_q.push_data;
  assign pop_en_o        = res_q.pop_en;
  assign extra_mcycles_o = res_q.extra_mcycles;

  // every accepted request yields a result through the request and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("request lost in pipeline");

  // no result without a matching earlier request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2))
    else $error("result without request");

  // a stack push and a stack pop never come from the same instruction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(push_en_o && pop_en_o))
    else $error("push and pop together");

  // halt gives either halt or halt bug, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(halt_enter_o && halt_bug_set_o))
    else $error("halt and halt bug together");

  // a pop always moves the stack pointer up by two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pop_en_o) |-> (sp_out_o == $past(sp_in_i, 2) + 16'd2))
    else $error("pop with wrong stack pointer");

endmodule
